// File: rtl/plcbae_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plcbae_pkg
// Shared widths, status codes and encoding constants of the logical binary
// address encoder.
// ----------------------------------------------------------------------------
package plcbae_pkg;

    localparam int COUNT_IN_W     = 4;
    localparam int LEVEL_IN_W     = 16;
    localparam int IN_LEVELS      = 7;
    localparam int S_TDATA_W      = 120;
    localparam int M_TDATA_W      = 8;

    localparam int STATUS_W       = 2;
    localparam int COUNT_W        = 3;
    localparam int LVL_W          = 10;

    localparam int MAX_LEVELS_DEF = 7;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_MANY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd3;

    localparam logic [LEVEL_IN_W-1:0] LEVEL_LIMIT   = 16'd999;
    localparam logic [LVL_W-1:0]      SHORT_LIMIT   = 10'd254;
    localparam logic [M_TDATA_W-1:0]  ESCAPE_BYTE   = 8'hFF;

endpackage

`default_nettype wire

// File: rtl/plcbae_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plcbae_front
// Classifies an incoming address: checks the level count and the used level
// values and packs status, count and levels into one queue entry.
// ----------------------------------------------------------------------------
module plcbae_front
    import plcbae_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    localparam int ENTRY_W   = STATUS_W + COUNT_W + MAX_LEVELS * LVL_W
) (
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic      [ENTRY_W-1:0]   entry
);

    logic [COUNT_IN_W-1:0]       count_in;
    logic [STATUS_W-1:0]         status;
    logic                        range_err;
    logic [MAX_LEVELS*LVL_W-1:0] levels_packed;
    logic [LEVEL_IN_W-1:0]       lv [MAX_LEVELS];

    assign count_in = s_tdata[COUNT_IN_W-1:0];

    for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_lvl
        assign lv[g] = s_tdata[COUNT_IN_W + g*LEVEL_IN_W +: LEVEL_IN_W];
        assign levels_packed[g*LVL_W +: LVL_W] = lv[g][LVL_W-1:0];
    end

    always_comb begin
        range_err = 1'b0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if ((COUNT_IN_W'(i) < count_in) && (lv[i] > LEVEL_LIMIT)) begin
                range_err = 1'b1;
            end
        end
        if (count_in == '0) begin
            status = STATUS_ZERO;
        end else if (count_in > COUNT_IN_W'(MAX_LEVELS)) begin
            status = STATUS_TOO_MANY;
        end else if (range_err) begin
            status = STATUS_RANGE;
        end else begin
            status = STATUS_OK;
        end
    end

    assign entry = {status, count_in[COUNT_W-1:0], levels_packed};

endmodule

`default_nettype wire

// File: rtl/plcbae_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plcbae_queue
// Short register queue that decouples address classification from byte
// emission.
// ----------------------------------------------------------------------------
module plcbae_queue
    import plcbae_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output logic      [WIDTH-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/plcbae_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plcbae_back
// Byte sequencer: walks the head entry and emits the mask byte, then each
// level as a short byte or an escape plus low and high byte (one zero byte
// for an error), one per cycle unless stalled, through an output register.
// ----------------------------------------------------------------------------
module plcbae_back
    import plcbae_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF,
    localparam int ENTRY_W   = STATUS_W + COUNT_W + MAX_LEVELS * LVL_W
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 head_valid,
    input  wire logic [ENTRY_W-1:0]   head_data,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic                      m_tlast,
    output logic      [STATUS_W-1:0]  m_tuser
);

    localparam int IDX_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    localparam logic [1:0] STEP_MASK = 2'd0;
    localparam logic [1:0] STEP_VAL  = 2'd1;
    localparam logic [1:0] STEP_LO   = 2'd2;
    localparam logic [1:0] STEP_HI   = 2'd3;

    logic [1:0]           step_reg, step_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 valid_reg, valid_next;
    logic [M_TDATA_W-1:0] data_reg;
    logic                 last_reg;
    logic [STATUS_W-1:0]  user_reg;

    logic [STATUS_W-1:0]  h_status;
    logic [COUNT_W-1:0]   h_count;
    logic [LVL_W-1:0]     levels [MAX_LEVELS];
    logic [LVL_W-1:0]     cur_val;
    logic                 lvl_last;
    logic                 load;
    logic                 done;
    logic [M_TDATA_W-1:0] byte_out;
    logic                 last_out;

    assign h_status = head_data[ENTRY_W-1 -: STATUS_W];
    assign h_count  = head_data[MAX_LEVELS*LVL_W +: COUNT_W];

    for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_lvl
        assign levels[g] = head_data[g*LVL_W +: LVL_W];
    end

    assign cur_val  = levels[idx_reg];
    assign lvl_last = ((COUNT_W'(idx_reg) + COUNT_W'(1)) == h_count);
    assign load     = head_valid && (!valid_reg || m_tready);
    assign pop      = load && done;

    always_comb begin
        byte_out  = '0;
        last_out  = 1'b0;
        done      = 1'b0;
        step_next = step_reg;
        idx_next  = idx_reg;
        if (h_status != STATUS_OK) begin
            last_out = 1'b1;
            done     = 1'b1;
        end else begin
            case (step_reg)
                STEP_MASK: begin
                    byte_out  = M_TDATA_W'((9'd1 << h_count) - 9'd1);
                    step_next = STEP_VAL;
                    idx_next  = '0;
                end
                STEP_VAL: begin
                    if (cur_val > SHORT_LIMIT) begin
                        byte_out  = ESCAPE_BYTE;
                        step_next = STEP_LO;
                    end else begin
                        byte_out = cur_val[M_TDATA_W-1:0];
                        if (lvl_last) begin
                            last_out = 1'b1;
                            done     = 1'b1;
                        end else begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                end
                STEP_LO: begin
                    byte_out  = cur_val[M_TDATA_W-1:0];
                    step_next = STEP_HI;
                end
                STEP_HI: begin
                    byte_out  = M_TDATA_W'(cur_val[LVL_W-1:M_TDATA_W]);
                    step_next = STEP_VAL;
                    if (lvl_last) begin
                        last_out = 1'b1;
                        done     = 1'b1;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                default: begin
                    step_next = STEP_MASK;
                end
            endcase
        end
        if (done) begin
            step_next = STEP_MASK;
            idx_next  = '0;
        end
    end

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= STEP_MASK;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (load) begin
                step_reg <= step_next;
                idx_reg  <= idx_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= byte_out;
            last_reg <= last_out;
            user_reg <= h_status;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = user_reg;

endmodule

`default_nettype wire

// File: rtl/plc_logical_binary_address_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plc_logical_binary_address_encoder
// Encodes one logical binary address per input transaction into a byte
// stream: a level mask, then each level as one byte or as 0xFF plus low and
// high byte; an invalid address yields one zero byte with an error status.
// ----------------------------------------------------------------------------
// An address takes one output byte per cycle while m_tready is high: 1 + sum
// over used levels of 1 (value up to 254) or 3 (value above 254), so 2 to 22
// bytes, and one byte for an error, all emitted by the back-end byte sequencer.
// Input transactions are taken in consecutive cycles while the two-entry queue
// between the classifier and the sequencer has room; a stalled output fills
// the queue after two addresses and then holds s_tready low until the
// sequencer finishes the address at its head.
module plc_logical_binary_address_encoder
    import plcbae_pkg::*;
#(
    parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // level_count[3:0], level_0[19:4], level_1[35:20], level_2[51:36],
    // level_3[67:52], level_4[83:68], level_5[99:84], level_6[115:100], zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // out_byte[7:0]
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic                      m_tlast,
    // status[1:0]
    output logic      [STATUS_W-1:0]  m_tuser
);

    localparam int ENTRY_W = STATUS_W + COUNT_W + MAX_LEVELS * LVL_W;

    logic [ENTRY_W-1:0] entry;
    logic [ENTRY_W-1:0] head_data;
    logic               full;
    logic               head_valid;
    logic               pop;

    assign s_tready = !full;

    plcbae_front #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_front (
        .s_tdata (s_tdata),
        .entry   (entry)
    );

    plcbae_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_tvalid),
        .push_data  (entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    plcbae_back #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

// File: rtl/plcbae_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plcbae_checker
// Port-level checks of the encoder input and output streams, bound to the
// top level.
// ----------------------------------------------------------------------------
module plcbae_checker
    import plcbae_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [S_TDATA_W-1:0] s_tdata,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tlast,
    input wire logic [STATUS_W-1:0]  m_tuser
);

    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != STATUS_OK)) |-> (m_tlast && (m_tdata == '0)))
        else $error("error result is not a single zero byte");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("gap inside an encoded address");

    a_escape_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && (m_tuser == STATUS_OK) && (m_tdata == ESCAPE_BYTE))
        |-> !m_tlast ##1 (m_tvalid && (m_tuser == STATUS_OK)))
        else $error("escape byte not followed by value bytes");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
        (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("output changed while stalled");

    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata)))
        else $error("input transaction withdrawn or changed while waiting");

endmodule

bind plc_logical_binary_address_encoder plcbae_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
